// ===== rtl/core/aea_pkg.sv =====
// Shared types, constants and tables of the auto exposure adaptation block.
package aea_pkg;

	// Fraction bits found by the iterative log2 (repeated squaring steps)
	localparam int LOG_BITS = 8;
	localparam int LOG_IT_W = $clog2(LOG_BITS);

	localparam logic [31:0] ONE_Q16     = 32'd65536;
	localparam logic [31:0] LOG2E_Q16   = 32'd94548;
	localparam logic [31:0] LOG10_2_Q16 = 32'd19728;
	localparam logic [16:0] KEY_BASE    = 17'd67502;
	// Key scaling divides by 4 * 0.18 in Q.16 (47184 = 16 * 2949): drop four bits,
	// then multiply by ceil(2^41 / 2949), exact for the 29-bit operand
	localparam logic [31:0] KEY_RECIP   = 32'd745684387;
	localparam logic [33:0] KEY_RND     = 34'd23592;  // half of 4 * 0.18 in Q.16
	localparam logic [33:0] TWO_P33     = 34'h2_0000_0000;

	localparam int DIV_W  = 34;
	localparam int DIVS_W = 20;

	// Configuration register indexes
	localparam logic [3:0] CFG_USE_ILLUM  = 4'd0;
	localparam logic [3:0] CFG_PRESERVE   = 4'd1;
	localparam logic [3:0] CFG_SPEED_UP   = 4'd2;
	localparam logic [3:0] CFG_SPEED_DN   = 4'd3;
	localparam logic [3:0] CFG_KEY_VALUE  = 4'd4;
	localparam logic [3:0] CFG_MIN_EV     = 4'd5;
	localparam logic [3:0] CFG_MAX_EV     = 4'd6;
	localparam logic [3:0] CFG_REF_LUM    = 4'd7;

	typedef struct packed {
		logic [31:0] illum_luminance;
		logic        illum_valid;
		logic [31:0] screen_luminance;
		logic        screen_valid;
		logic [15:0] frame_time;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] exposure_ev;
		logic [31:0]        adapted_lum_out;
		logic [15:0]        scene_key;
		logic               updated;
	} result_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [31:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// 2^-(2^-(k+1)) in Q.16
	function automatic logic [15:0] exp2_neg(input logic [3:0] k);
		logic [15:0] v;
		unique case (k)
			4'd0:    v = 16'd46341;
			4'd1:    v = 16'd55109;
			4'd2:    v = 16'd60097;
			4'd3:    v = 16'd62757;
			4'd4:    v = 16'd64132;
			4'd5:    v = 16'd64830;
			4'd6:    v = 16'd65182;
			4'd7:    v = 16'd65359;
			4'd8:    v = 16'd65447;
			4'd9:    v = 16'd65492;
			4'd10:   v = 16'd65514;
			4'd11:   v = 16'd65525;
			4'd12:   v = 16'd65530;
			4'd13:   v = 16'd65533;
			default: v = 16'd65535;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/aea_chan_if.sv =====
// Handshake channels of the auto exposure adaptation block.
interface aea_frame_if import aea_pkg::*; ;
	logic   valid;
	logic   ready;
	frame_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aea_result_if import aea_pkg::*; ;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aea_cfg_if import aea_pkg::*; ;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/aea_mul.sv =====
// Shared unsigned multiplier with registered product.
module aea_mul import aea_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {32'd0, a} * {32'd0, b};
	end

	assign p = p_q;
endmodule

// ===== rtl/core/aea_div.sv =====
// Restoring divider, one quotient bit per cycle.
module aea_div import aea_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== rtl/core/auto_exposure_adaptation.sv =====
// Auto exposure with eye adaptation: sequencer around a shared multiplier and divider.
// Sequence: an accepted updating frame runs eight squaring steps per log2, four logs for
//   the EV and one exp product per set fraction bit; the automatic key adds two logs and
//   two divisions; a held frame goes straight to its result.
// Throughput: one frame at a time; the next request is taken the cycle after the result
//   is loaded, and a result left waiting holds the sequencer.
// Reset: arst_n clears configuration to defaults and adaptation state to zero at once.
module auto_exposure_adaptation import aea_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	aea_frame_if.sink     frame,
	aea_result_if.source  result,
	aea_cfg_if.sink       cfg
);
	// Sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_B0   = 5'd1;
	localparam logic [4:0] S_B1   = 5'd2;
	localparam logic [4:0] S_B2   = 5'd3;
	localparam logic [4:0] S_E    = 5'd4;
	localparam logic [4:0] S_E2   = 5'd5;
	localparam logic [4:0] S_E3   = 5'd6;
	localparam logic [4:0] S_B4   = 5'd7;
	localparam logic [4:0] S_KS   = 5'd8;
	localparam logic [4:0] S_K0   = 5'd9;
	localparam logic [4:0] S_K1   = 5'd10;
	localparam logic [4:0] S_K2   = 5'd11;
	localparam logic [4:0] S_K3   = 5'd12;
	localparam logic [4:0] S_K4   = 5'd13;
	localparam logic [4:0] S_K5   = 5'd14;
	localparam logic [4:0] S_V0   = 5'd15;
	localparam logic [4:0] S_V1   = 5'd16;
	localparam logic [4:0] S_V2   = 5'd17;
	localparam logic [4:0] S_LN   = 5'd18;
	localparam logic [4:0] S_LM   = 5'd19;
	localparam logic [4:0] S_LQ   = 5'd20;
	localparam logic [4:0] S_DONE = 5'd21;

	logic [4:0] state_q, ret_q;

	// Configuration registers
	logic        umet_q, pres_q;
	logic [15:0] spd_up_q, spd_dn_q, keyv_q, min_ev_q;
	logic [14:0] max_ev_q;
	logic [19:0] ref_lum_q;

	// Adaptation state
	logic [31:0] adapted_q;
	logic        started_q;
	logic [15:0] last_ev_q, last_key_q;

	// Per-frame working registers
	logic [15:0]     dt_q;
	logic            up_q;
	logic [31:0]     diff_q;
	logic [5:0]      n_q;
	logic [15:0]     f_q;
	logic [16:0]     e_q;
	logic [3:0]      k_q;
	logic            kflag_q;
	logic [15:0]     key_q, refkey_q;
	logic [1:0]      j_q;
	logic signed [25:0] acc_q;

	// log2 unit registers
	logic [33:0]         w_q;
	logic [5:0]          s_q;
	logic [30:0]         m_q;
	logic [LOG_BITS-1:0] fr_q;
	logic [LOG_IT_W-1:0] it_q;
	logic                frac14_q;

	// Result registers and output stage
	result_t res_q;
	result_t out_q;
	logic    out_v_q;

	// Shared units
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	aea_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	aea_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Target selection on the incoming frame
	logic        take;
	logic        sel_illum, sel_any;
	logic [31:0] target;

	assign take      = frame.valid && frame.ready;
	assign sel_illum = umet_q && frame.data.illum_valid;
	assign sel_any   = sel_illum || frame.data.screen_valid;
	assign target    = sel_illum ? frame.data.illum_luminance : frame.data.screen_luminance;

	// log2 result: integer part from the shift count, fraction from squaring
	logic signed [7:0]  lg_exp;
	logic [15:0]        lg_frac;
	logic signed [23:0] lg;
	logic [22:0]        l2u;

	assign lg_exp  = 8'sd33 - $signed({2'b00, s_q}) - (frac14_q ? 8'sd14 : 8'sd16);
	assign lg_frac = 16'({fr_q, {(16 - LOG_BITS){1'b0}}});
	assign lg      = $signed({lg_exp, lg_frac});
	assign l2u     = lg[23] ? 23'd0 : lg[22:0];

	// Squaring step
	logic [31:0] sq;
	assign sq = mul_p[61:30];

	// Blend factor from the exp product
	logic [16:0] e_sh;
	logic [16:0] blend;
	assign e_sh  = (n_q >= 6'd17) ? 17'd0 : (e_q >> n_q);
	assign blend = 17'(ONE_Q16) - e_sh;

	// Key stage helpers
	logic [19:0] lg10, den;
	logic [16:0] kk;
	logic [33:0] key_num;
	logic [22:0] key_quo;
	logic [15:0] key_sat, key_fixed;
	assign lg10      = 20'((mul_p + 64'd32768) >> 16);
	assign den       = 20'(2 * ONE_Q16) + lg10;
	assign kk        = KEY_BASE - div_rsp.quotient[16:0];
	assign key_num   = mul_p[33:0] + KEY_RND;
	assign key_quo   = mul_p[63:41];
	assign key_sat   = (key_quo > 23'd65535) ? 16'hFFFF : key_quo[15:0];
	assign key_fixed = 16'(({1'b0, keyv_q} + 17'd2) >> 2);

	// Operand of the next log2
	logic [33:0] log_k, log_v;
	logic        log_v14;
	assign log_k = (kflag_q ? {14'd0, ref_lum_q} : {2'd0, adapted_q}) + 34'(ONE_Q16);
	always_comb begin
		log_v   = 34'd1;
		log_v14 = 1'b0;
		unique case (j_q)
			2'd0: begin
				log_v   = (key_q == 16'd0) ? 34'd1 : {18'd0, key_q};
				log_v14 = 1'b1;
			end
			2'd1: log_v = (adapted_q == 32'd0) ? 34'd1 : {2'd0, adapted_q};
			2'd2: begin
				log_v   = (refkey_q == 16'd0) ? 34'd1 : {18'd0, refkey_q};
				log_v14 = 1'b1;
			end
			default: log_v = (ref_lum_q == 20'd0) ? 34'd1 : {14'd0, ref_lum_q};
		endcase
	end

	// EV rounding and clamps: lower clamp first, then upper
	logic signed [25:0] ev_r, ev_lo, ev_hi, ev_c1, ev_c2;
	assign ev_r  = (acc_q + 26'sd16) >>> 5;
	assign ev_lo = $signed({{10{min_ev_q[15]}}, min_ev_q});
	assign ev_hi = $signed({11'd0, max_ev_q});
	assign ev_c1 = (ev_r < ev_lo) ? ev_lo : ev_r;
	assign ev_c2 = (ev_c1 > ev_hi) ? ev_hi : ev_c1;

	// Shared unit operand selection
	always_comb begin
		mul_a            = 32'd0;
		mul_b            = 32'd0;
		div_req.start    = 1'b0;
		div_req.dividend = TWO_P33;
		div_req.divisor  = den;
		unique case (state_q)
			S_B0: begin
				mul_a = {16'd0, dt_q};
				mul_b = {16'd0, up_q ? spd_up_q : spd_dn_q};
			end
			S_B1: begin
				mul_a = {11'd0, mul_p[31:11]};
				mul_b = LOG2E_Q16;
			end
			S_E: begin
				mul_a = {15'd0, e_q};
				mul_b = {16'd0, exp2_neg(k_q)};
			end
			S_E3: begin
				mul_a = diff_q;
				mul_b = {15'd0, blend};
			end
			S_LM: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_K1: begin
				mul_a = {9'd0, l2u};
				mul_b = LOG10_2_Q16;
			end
			S_K2: div_req.start = 1'b1;
			S_K3: begin
				mul_a = {15'd0, kk};
				mul_b = {16'd0, keyv_q};
			end
			S_K4: begin
				// scale by key_value / (4 * 0.18) through the reciprocal
				mul_a = 32'(key_num >> 4);
				mul_b = KEY_RECIP;
			end
			default: begin
			end
		endcase
	end

	assign frame.ready  = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_v_q;
	assign result.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			umet_q     <= 1'b1;
			pres_q     <= 1'b1;
			spd_up_q   <= 16'd16384;
			spd_dn_q   <= 16'd6144;
			keyv_q     <= 16'd11796;
			min_ev_q   <= 16'hE000;
			max_ev_q   <= 15'd16384;
			ref_lum_q  <= 20'd131072;
			adapted_q  <= '0;
			started_q  <= 1'b0;
			last_ev_q  <= '0;
			last_key_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			// Register writes
			if (cfg.valid) begin
				unique case (cfg.data.index)
					CFG_USE_ILLUM: umet_q    <= cfg.data.wdata[0];
					CFG_PRESERVE:  pres_q    <= cfg.data.wdata[0];
					CFG_SPEED_UP:  spd_up_q  <= cfg.data.wdata[15:0];
					CFG_SPEED_DN:  spd_dn_q  <= cfg.data.wdata[15:0];
					CFG_KEY_VALUE: keyv_q    <= cfg.data.wdata[15:0];
					CFG_MIN_EV:    min_ev_q  <= cfg.data.wdata[15:0];
					CFG_MAX_EV:    max_ev_q  <= cfg.data.wdata[14:0];
					CFG_REF_LUM:   ref_lum_q <= cfg.data.wdata[19:0];
					default: begin
					end
				endcase
			end

			// Load a finished result, drop it once taken
			if (state_q == S_DONE && (!out_v_q || result.ready)) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						dt_q <= frame.data.frame_time;
						if (!sel_any) begin
							// hold: report the previous values
							res_q.exposure_ev     <= $signed(last_ev_q);
							res_q.adapted_lum_out <= adapted_q;
							res_q.scene_key       <= last_key_q;
							res_q.updated         <= 1'b0;
							state_q               <= S_DONE;
						end else if (!started_q) begin
							// first update snaps to the target
							adapted_q <= target;
							started_q <= 1'b1;
							state_q   <= S_KS;
						end else begin
							up_q    <= target > adapted_q;
							diff_q  <= (target > adapted_q) ? target - adapted_q
							                                : adapted_q - target;
							state_q <= S_B0;
						end
					end
				end
				S_B0: state_q <= S_B1;
				S_B1: state_q <= S_B2;
				S_B2: begin
					n_q     <= 6'(mul_p[37:0] + 38'd32768 >> 32);
					f_q     <= mul_p[31:16] + {15'd0, mul_p[15]};
					e_q     <= 17'(ONE_Q16);
					k_q     <= '0;
					state_q <= S_E;
				end
				S_E: begin
					// multiply only where the fraction bit is set
					if (f_q[15]) begin
						state_q <= S_E2;
					end else begin
						f_q <= {f_q[14:0], 1'b0};
						k_q <= k_q + 4'd1;
						if (k_q == 4'd15) begin
							state_q <= S_E3;
						end
					end
				end
				S_E2: begin
					e_q <= 17'((mul_p + 64'd32768) >> 16);
					f_q <= {f_q[14:0], 1'b0};
					k_q <= k_q + 4'd1;
					state_q <= (k_q == 4'd15) ? S_E3 : S_E;
				end
				S_E3: state_q <= S_B4;
				S_B4: begin
					adapted_q <= up_q ? adapted_q + mul_p[47:16] : adapted_q - mul_p[47:16];
					state_q   <= S_KS;
				end
				S_KS: begin
					if (pres_q) begin
						kflag_q <= 1'b0;
						state_q <= S_K0;
					end else begin
						key_q    <= key_fixed;
						refkey_q <= key_fixed;
						j_q      <= '0;
						acc_q    <= '0;
						state_q  <= S_V0;
					end
				end
				S_K0: begin
					w_q      <= log_k;
					s_q      <= '0;
					frac14_q <= 1'b0;
					ret_q    <= S_K1;
					state_q  <= S_LN;
				end
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_K3;
				S_K3: begin
					if (div_rsp.done) begin
						state_q <= S_K4;
					end
				end
				S_K4: state_q <= S_K5;
				S_K5: begin
					if (!kflag_q) begin
						key_q   <= key_sat;
						kflag_q <= 1'b1;
						state_q <= S_K0;
					end else begin
						refkey_q <= key_sat;
						j_q      <= '0;
						acc_q    <= '0;
						state_q  <= S_V0;
					end
				end
				S_V0: begin
					w_q      <= log_v;
					s_q      <= '0;
					frac14_q <= log_v14;
					ret_q    <= S_V1;
					state_q  <= S_LN;
				end
				S_V1: begin
					// key terms add, luminance terms subtract, reference terms flip
					if (j_q == 2'd0 || j_q == 2'd3) begin
						acc_q <= acc_q + $signed({{2{lg[23]}}, lg});
					end else begin
						acc_q <= acc_q - $signed({{2{lg[23]}}, lg});
					end
					j_q     <= j_q + 2'd1;
					state_q <= (j_q == 2'd3) ? S_V2 : S_V0;
				end
				S_V2: begin
					res_q.exposure_ev     <= ev_c2[15:0];
					res_q.adapted_lum_out <= adapted_q;
					res_q.scene_key       <= key_q;
					res_q.updated         <= 1'b1;
					last_ev_q             <= ev_c2[15:0];
					last_key_q            <= key_q;
					state_q               <= S_DONE;
				end
				S_LN: begin
					// normalize: nibble steps while the top is clear, then single bits
					if (w_q[33]) begin
						m_q     <= w_q[33:3];
						fr_q    <= '0;
						it_q    <= '0;
						state_q <= S_LM;
					end else if (w_q[33:30] == 4'd0) begin
						w_q <= {w_q[29:0], 4'd0};
						s_q <= s_q + 6'd4;
					end else begin
						w_q <= {w_q[32:0], 1'b0};
						s_q <= s_q + 6'd1;
					end
				end
				S_LM: state_q <= S_LQ;
				S_LQ: begin
					if (sq[31]) begin
						m_q  <= sq[31:1];
						fr_q <= {fr_q[LOG_BITS-2:0], 1'b1};
					end else begin
						m_q  <= sq[30:0];
						fr_q <= {fr_q[LOG_BITS-2:0], 1'b0};
					end
					it_q    <= it_q + 1'b1;
					state_q <= (it_q == LOG_IT_W'(LOG_BITS - 1)) ? ret_q : S_LM;
				end
				S_DONE: begin
					// advance once the output stage is free
					if (!out_v_q || result.ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Before the first update the adapted luminance stays at its reset value
	a_not_started: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> adapted_q == 32'd0)
		else $error("adapted luminance moved before first update");

	// The divider is never restarted while busy
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A held frame reports the current adapted luminance
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !res_q.updated) |-> res_q.adapted_lum_out == adapted_q)
		else $error("held frame lost adapted luminance");

	// Normalization never shifts past the word
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LN |-> s_q <= 6'd33)
		else $error("log2 normalization overran");
endmodule
